[hdl/qlbs_pkg.sv]
// Shared types, constants and key function for the quantized LLR bitonic sorter.
package qlbs_pkg;

  localparam int MAX_LEN_DEF       = 64;
  localparam int LLR_FRAC_BITS_DEF = 4;

  localparam int LLR_W      = 11;
  localparam int MAG_W      = 5;
  localparam int IDX_W      = 6;
  localparam int NET_LOG2   = 6;
  localparam int SZ_W       = NET_LOG2 + 1;
  localparam int BANK_AW    = NET_LOG2 - 1;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int LOG_W      = 3;
  localparam int TIE_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [MAG_W-1:0] MAG_MAX = 5'd31;

  localparam logic [2:0] MODE_FULL    = 3'd1;
  localparam logic [2:0] MODE_MSB2    = 3'd2;
  localparam logic [2:0] MODE_MSB3    = 3'd3;
  localparam logic [2:0] MODE_MSB4    = 3'd4;
  localparam logic [2:0] MODE_MSB3_L1 = 3'd5;
  localparam logic [2:0] MODE_MSB3_L2 = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SORT_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIE_LOG2  = 2'd2;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [IDX_W-1:0] idx;
  } entry_t;

  typedef struct packed {
    logic               we;
    logic [BANK_AW-1:0] waddr;
    entry_t             wdata;
    logic [BANK_AW-1:0] raddr;
  } bank_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_PAD,
    ST_SORT,
    ST_GAP,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } state_t;

  // Composite comparison key: primary bits first, tie-break bits below them.
  function automatic logic [MAG_W-1:0] order_key(logic [MAG_W-1:0] m, logic [2:0] mode,
                                                 logic tb);
    logic [MAG_W-1:0] k;
    case (mode)
      MODE_MSB2:    k = {3'b000, m[4:3]};
      MODE_MSB3:    k = {2'b00, m[4:2]};
      MODE_MSB4:    k = {1'b0, m[4:1]};
      MODE_MSB3_L1: k = tb ? {1'b0, m[4:2], m[0]} : {2'b00, m[4:2]};
      MODE_MSB3_L2: k = tb ? m : {2'b00, m[4:2]};
      default:      k = m;
    endcase
    return k;
  endfunction

endpackage

[hdl/qlbs_bank.sv]
// One bank of entry storage: one write port and one registered read port.
module qlbs_bank (
  input  logic                clk,
  input  qlbs_pkg::bank_req_t req,
  output qlbs_pkg::entry_t    rdata
);
  import qlbs_pkg::*;

  entry_t mem [BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

[hdl/quantized_llr_bitonic_sorter_top.sv]
// Top level of the quantized LLR bitonic sorter: loading, padding, sorting network and output.
// Loading takes one input item per cycle. After the last item: a set-up state, one padding entry
// per cycle, s*(s+1)/2 network steps (s = log2 of the sort size, size/2 compare-exchanges per
// step at one per cycle on the two-bank store, each step closed by a gap state), a read state,
// then each result is loaded and held until taken; an error result is presented from set-up.
// Reset restores the control state and register defaults; the stores are not cleared.
module quantized_llr_bitonic_sorter_top #(
  parameter int MAX_LEN       = qlbs_pkg::MAX_LEN_DEF,
  parameter int LLR_FRAC_BITS = qlbs_pkg::LLR_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,   // [10:0] llr
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [5:0] index
  output logic                           m_tlast,
  output logic                           m_tuser,   // [0] error
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [qlbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qlbs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import qlbs_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 2);
  localparam int MW    = ((LLR_W > MAG_W + LLR_FRAC_BITS) ? LLR_W : MAG_W + LLR_FRAC_BITS) + 1;
  localparam logic [MW-1:0] LIM  = MW'(31 << LLR_FRAC_BITS);
  localparam logic [MW-1:0] HALF = MW'((1 << LLR_FRAC_BITS) >> 1);

  function automatic logic [MAG_W-1:0] llr_mag(logic [LLR_W-1:0] v);
    logic [LLR_W-1:0] a;
    logic [MW-1:0]    ac;
    logic [MW-1:0]    r;
    a  = v[LLR_W-1] ? LLR_W'(-v) : v;
    ac = (MW'(a) > LIM) ? LIM : MW'(a);
    r  = ac + HALF;
    return MAG_W'(r >> LLR_FRAC_BITS);
  endfunction

  function automatic logic [LOG_W-1:0] auto_log2(logic [SZ_W-1:0] n);
    logic [LOG_W-1:0] s;
    s = LOG_W'(NET_LOG2);
    for (int b = NET_LOG2; b >= 0; b--) begin
      if ((SZ_W'(1) << b) >= n) begin
        s = LOG_W'(b);
      end
    end
    return s;
  endfunction

  state_t state, state_next;

  logic [2:0]       mode;
  logic [LOG_W-1:0] sort_log2;
  logic [TIE_W-1:0] tie_log2;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] n_reg;
  logic [LOG_W-1:0] sl;
  logic [TIE_W-1:0] tl;
  logic [LOG_W-1:0] wl;
  logic [LOG_W-1:0] jl;
  logic [BANK_AW-1:0] pcnt;
  logic             last_stage;
  logic [IDX_W-1:0] pad_i;
  logic [IDX_W-1:0] kcnt;

  logic               pend_valid;
  logic               pend_par;
  logic [BANK_AW-1:0] pend_ia;
  logic [BANK_AW-1:0] pend_la;
  logic               pend_asc;
  logic               pend_tb;

  logic             out_valid;
  logic [IDX_W-1:0] out_index;
  logic             out_last;
  logic             out_error;

  bank_req_t req0, req1;
  entry_t    rd0, rd1;

  qlbs_bank u_bank0 (.clk(clk), .req(req0), .rdata(rd0));
  qlbs_bank u_bank1 (.clk(clk), .req(req1), .rdata(rd1));

  logic             in_acc;
  logic             count_ok;
  logic [CNT_W-1:0] n_new;
  logic [IDX_W-1:0] load_addr;
  entry_t           load_entry;
  logic [LOG_W-1:0] sl_calc;
  logic [SZ_W-1:0]  size_calc;
  logic [SZ_W-1:0]  size_cur;
  logic             err;
  logic             pad_done;

  logic [IDX_W-1:0]   p6;
  logic [IDX_W-1:0]   low_mask;
  logic [IDX_W-1:0]   jbit;
  logic [IDX_W-1:0]   pair_i;
  logic [IDX_W-1:0]   pair_l;
  logic [IDX_W:0]     pair_i7;
  logic               pair_par;
  logic [BANK_AW-1:0] pmax;
  logic               tb_mode;
  logic               tb_now;

  entry_t           mi, ml, ni, nl;
  logic [MAG_W-1:0] ki, kl;
  logic             swap;
  logic [IDX_W-1:0] kcnt_inc;
  logic [IDX_W-1:0] emit_sel;

  assign in_acc     = s_tvalid & s_tready;
  assign count_ok   = count < CNT_W'(MAX_LEN);
  assign n_new      = count_ok ? count + CNT_W'(1) : CNT_W'(MAX_LEN + 1);
  assign load_addr  = IDX_W'(count);
  assign load_entry = '{mag: llr_mag(s_tdata[LLR_W-1:0]), idx: load_addr};

  assign sl_calc   = (sort_log2 != '0) ?
                     ((sort_log2 > LOG_W'(NET_LOG2)) ? LOG_W'(NET_LOG2) : sort_log2) :
                     auto_log2(SZ_W'(n_reg));
  assign size_calc = SZ_W'(1) << sl_calc;
  assign size_cur  = SZ_W'(1) << sl;
  assign err       = (n_reg > CNT_W'(MAX_LEN)) || (SZ_W'(n_reg) > size_calc);
  assign pad_done  = (SZ_W'(pad_i) == size_cur - SZ_W'(1));

  assign p6       = IDX_W'(pcnt);
  assign jbit     = IDX_W'(1) << jl;
  assign low_mask = jbit - IDX_W'(1);
  assign pair_i   = (p6 & low_mask) | ((p6 << 1) & ~low_mask & ~jbit);
  assign pair_l   = pair_i | jbit;
  assign pair_i7  = {1'b0, pair_i};
  assign pair_par = ^pair_i;
  assign pmax     = BANK_AW'((size_cur >> 1) - SZ_W'(1));
  assign tb_mode  = (mode == MODE_MSB3_L1) || (mode == MODE_MSB3_L2);
  assign tb_now   = tb_mode && ((5'(wl) + 5'd1) >= 5'(tl));

  assign mi   = pend_par ? rd1 : rd0;
  assign ml   = pend_par ? rd0 : rd1;
  assign ki   = order_key(mi.mag, mode, pend_tb);
  assign kl   = order_key(ml.mag, mode, pend_tb);
  assign swap = pend_asc ? (ki > kl) : (ki < kl);
  assign ni   = swap ? ml : mi;
  assign nl   = swap ? mi : ml;

  assign kcnt_inc = kcnt + IDX_W'(1);
  assign emit_sel = (^kcnt) ? rd1.idx : rd0.idx;

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    req0       = '0;
    req1       = '0;
    if (pend_valid) begin
      req0.we    = 1'b1;
      req1.we    = 1'b1;
      req0.waddr = pend_par ? pend_la : pend_ia;
      req0.wdata = pend_par ? nl : ni;
      req1.waddr = pend_par ? pend_ia : pend_la;
      req1.wdata = pend_par ? ni : nl;
    end
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (in_acc && count_ok) begin
          if (^load_addr) begin
            req1.we    = 1'b1;
            req1.waddr = load_addr[IDX_W-1:1];
            req1.wdata = load_entry;
          end else begin
            req0.we    = 1'b1;
            req0.waddr = load_addr[IDX_W-1:1];
            req0.wdata = load_entry;
          end
        end
        if (in_acc && s_tlast) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (err) begin
          state_next = ST_EMIT_HOLD;
        end else if (SZ_W'(n_reg) < size_calc) begin
          state_next = ST_PAD;
        end else if (sl_calc != '0) begin
          state_next = ST_SORT;
        end else begin
          state_next = ST_EMIT_RD;
        end
      end
      ST_PAD: begin
        if (^pad_i) begin
          req1.we    = 1'b1;
          req1.waddr = pad_i[IDX_W-1:1];
          req1.wdata = '{mag: MAG_MAX, idx: pad_i};
        end else begin
          req0.we    = 1'b1;
          req0.waddr = pad_i[IDX_W-1:1];
          req0.wdata = '{mag: MAG_MAX, idx: pad_i};
        end
        if (pad_done) begin
          state_next = ST_SORT;
        end
      end
      ST_SORT: begin
        req0.raddr = pair_par ? pair_l[IDX_W-1:1] : pair_i[IDX_W-1:1];
        req1.raddr = pair_par ? pair_i[IDX_W-1:1] : pair_l[IDX_W-1:1];
        if (pcnt == pmax) begin
          state_next = ST_GAP;
        end
      end
      ST_GAP: begin
        state_next = last_stage ? ST_EMIT_RD : ST_SORT;
      end
      ST_EMIT_RD: begin
        req0.raddr = kcnt[IDX_W-1:1];
        req1.raddr = kcnt[IDX_W-1:1];
        state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        state_next = ST_EMIT_HOLD;
      end
      ST_EMIT_HOLD: begin
        if (m_tready) begin
          if (out_last) begin
            state_next = ST_IDLE;
          end else begin
            req0.raddr = kcnt_inc[IDX_W-1:1];
            req1.raddr = kcnt_inc[IDX_W-1:1];
            state_next = ST_EMIT_LD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_FULL;
      sort_log2 <= '0;
      tie_log2  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:      mode      <= cfg_data[2:0];
        REG_SORT_LOG2: sort_log2 <= cfg_data[LOG_W-1:0];
        REG_TIE_LOG2:  tie_log2  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      pend_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (s_tlast) begin
              n_reg <= n_new;
              count <= '0;
            end else begin
              count <= n_new;
            end
          end
        end
        ST_PREP: begin
          sl         <= sl_calc;
          tl         <= (tie_log2 != '0) ? tie_log2 : TIE_W'(sl_calc);
          wl         <= LOG_W'(1);
          jl         <= '0;
          pcnt       <= '0;
          last_stage <= 1'b0;
          kcnt       <= '0;
          pad_i      <= IDX_W'(n_reg);
          if (err) begin
            out_valid <= 1'b1;
            out_index <= '0;
            out_last  <= 1'b1;
            out_error <= 1'b1;
          end
        end
        ST_PAD: begin
          pad_i <= pad_i + IDX_W'(1);
        end
        ST_SORT: begin
          pend_valid <= 1'b1;
          pend_par   <= pair_par;
          pend_ia    <= pair_i[IDX_W-1:1];
          pend_la    <= pair_l[IDX_W-1:1];
          pend_asc   <= ~pair_i7[wl];
          pend_tb    <= tb_now;
          if (pcnt == pmax) begin
            pcnt       <= '0;
            last_stage <= (jl == '0) && (wl == sl);
            if (jl == '0) begin
              if (wl != sl) begin
                wl <= wl + LOG_W'(1);
                jl <= wl;
              end
            end else begin
              jl <= jl - LOG_W'(1);
            end
          end else begin
            pcnt <= pcnt + BANK_AW'(1);
          end
        end
        ST_EMIT_LD: begin
          out_valid <= 1'b1;
          out_index <= emit_sel;
          out_last  <= (SZ_W'(kcnt) + SZ_W'(1)) == SZ_W'(n_reg);
          out_error <= 1'b0;
        end
        ST_EMIT_HOLD: begin
          if (m_tready) begin
            out_valid <= 1'b0;
            if (!out_last) begin
              kcnt <= kcnt_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tvalid  = out_valid;
  assign m_tdata   = {2'b00, out_index};
  assign m_tlast   = out_last;
  assign m_tuser   = out_error;
  assign cfg_ready = 1'b1;

endmodule

[hdl/qlbs_checker.sv]
// Port-level checks for the quantized LLR bitonic sorter, bound to the top level.
module qlbs_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser
);

  // Loading and result delivery never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while a result is pending");

  // An error result is always the single, final result of its run.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == 8'd0))
    else $error("malformed error result");

  // After the final result the block is ready for a new vector next cycle.
  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
    else $error("block not ready after the final result");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                 && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind quantized_llr_bitonic_sorter_top qlbs_checker u_qlbs_checker (.*);

[bench/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the quantized LLR bitonic sorter top level.
module testbench;
  import qlbs_pkg::*;

  localparam int MAX_LEN       = MAX_LEN_DEF;
  localparam int FRAC_BITS     = LLR_FRAC_BITS_DEF;
  localparam int RANDOM_ITEMS  = 220;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 5000;

  localparam logic [2:0] MODE_SPARE_LO = 3'd0;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             last_res;
    logic             error;
  } result_t;

  typedef enum logic {ROW_LLR, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [LLR_W-1:0] llr;
    logic             last;
    logic [2:0]       mode;
    logic [2:0]       sort_log2;
    logic [3:0]       tie_log2;
    logic             typed;
    result_t          want;
  } directed_row_t;

  localparam result_t NO_RESULT = '0;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [15:0]           s_tdata;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [7:0]            m_tdata;
  logic                  m_tlast;
  logic                  m_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state: configuration, loaded magnitudes and the pending sorted order.
  logic [2:0]       cur_mode = MODE_FULL;
  logic [2:0]       cur_sort = 3'd0;
  logic [3:0]       cur_tie  = 4'd0;
  logic [MAG_W-1:0] stored_mag [MAX_LEN];
  int               loaded_count = 0;
  result_t          new_order [$];
  result_t          sorted_order_q [$];
  int               failures = 0;
  int               quiet_cycles = 0;

  directed_row_t directed_rows [30];

  quantized_llr_bitonic_sorter_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [MAG_W-1:0] llr_magnitude(logic signed [LLR_W-1:0] llr);
    int v;
    v = llr;
    if (v < 0) v = -v;
    if (v > (31 << FRAC_BITS)) v = 31 << FRAC_BITS;
    if (FRAC_BITS == 0) return MAG_W'(v);
    return MAG_W'((v + ((1 << FRAC_BITS) >> 1)) >> FRAC_BITS);
  endfunction

  function automatic bit moves_after(logic [MAG_W-1:0] a, logic [MAG_W-1:0] b, int shift,
                                     int lmask, bit tb, bit up);
    int pa, pb, la, lb;
    pa = a >> shift;
    pb = b >> shift;
    if (pa != pb) return up ? (pa > pb) : (pa < pb);
    if (!tb) return 1'b0;
    la = a & lmask;
    lb = b & lmask;
    return up ? (la > lb) : (la < lb);
  endfunction

  // Loads one LLR; on the last item, fills new_order with sorted positions or an error.
  task automatic rank_llr(logic [LLR_W-1:0] llr, logic last);
    int n, size, tie, shift, lmask, w, j, i, l, tmp_pos;
    bit tb_mode, tb;
    logic [MAG_W-1:0] mag [64];
    logic [IDX_W-1:0] pos [64];
    logic [MAG_W-1:0] tmp_mag;
    new_order.delete();
    if (loaded_count < MAX_LEN) begin
      stored_mag[loaded_count] = llr_magnitude(llr);
      loaded_count++;
    end else begin
      loaded_count = MAX_LEN + 1;
    end
    if (!last) return;
    n = loaded_count;
    loaded_count = 0;
    if (cur_sort != 0) begin
      size = 1 << ((cur_sort > 6) ? 6 : cur_sort);
    end else begin
      size = 1;
      while (size < n && size < 64) size = size << 1;
    end
    if (n > MAX_LEN || n > size) begin
      new_order.push_back('{index: '0, last_res: 1'b1, error: 1'b1});
      return;
    end
    tie = (cur_tie != 0) ? (1 << cur_tie) : size;
    for (i = 0; i < size; i++) begin
      mag[i] = (i < n) ? stored_mag[i] : MAG_MAX;
      pos[i] = IDX_W'(i);
    end
    tb_mode = 1'b0;
    lmask = 0;
    case (cur_mode)
      MODE_MSB2:    shift = 3;
      MODE_MSB3:    shift = 2;
      MODE_MSB4:    shift = 1;
      MODE_MSB3_L1: begin
        shift = 2;
        lmask = 1;
        tb_mode = 1'b1;
      end
      MODE_MSB3_L2: begin
        shift = 2;
        lmask = 3;
        tb_mode = 1'b1;
      end
      default:      shift = 0;
    endcase
    for (w = 2; w <= size; w = w << 1) begin
      tb = tb_mode && (w >= (tie >> 1));
      for (j = w >> 1; j > 0; j = j >> 1) begin
        for (i = 0; i < size; i++) begin
          l = i ^ j;
          if (l > i && l < size &&
              moves_after(mag[i], mag[l], shift, lmask, tb, (i & w) == 0)) begin
            tmp_mag = mag[i];
            mag[i] = mag[l];
            mag[l] = tmp_mag;
            tmp_pos = pos[i];
            pos[i] = pos[l];
            pos[l] = IDX_W'(tmp_pos);
          end
        end
      end
    end
    for (i = 0; i < n; i++)
      new_order.push_back('{index: pos[i], last_res: (i == n - 1), error: 1'b0});
  endtask

  task automatic send_llr(logic [LLR_W-1:0] llr, logic last, logic typed, result_t want,
                          bit steady);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, llr};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    rank_llr(llr, last);
    if (typed) begin
      sorted_order_q.push_back(want);
    end else begin
      foreach (new_order[k]) sorted_order_q.push_back(new_order[k]);
    end
  endtask

  task automatic wait_drained();
    while (sorted_order_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(logic [2:0] mode, logic [2:0] sort_log2, logic [3:0] tie_log2);
    s_tvalid <= 1'b0;
    wait_drained();
    write_reg(REG_MODE, {1'b0, mode});
    write_reg(REG_SORT_LOG2, {1'b0, sort_log2});
    write_reg(REG_TIE_LOG2, tie_log2);
    cfg_valid <= 1'b0;
    cur_mode = mode;
    cur_sort = sort_log2;
    cur_tie  = tie_log2;
  endtask

  initial begin : sink
    result_t got, want;
    int stall;
    bit steady;
    steady = 1'b0;
    m_tready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = '{index: m_tdata[IDX_W-1:0], last_res: m_tlast, error: m_tuser};
      if (sorted_order_q.size() == 0) begin
        $error("unexpected item: index %0d, last_res %0d, error %0d",
               got.index, got.last_res, got.error);
        failures++;
      end else begin
        want = sorted_order_q.pop_front();
        if (got.index !== want.index) begin
          $error("index: expected %0d, got %0d", want.index, got.index);
          failures++;
        end
        if (got.last_res !== want.last_res) begin
          $error("last_res: expected %0d, got %0d", want.last_res, got.last_res);
          failures++;
        end
        if (got.error !== want.error) begin
          $error("error: expected %0d, got %0d", want.error, got.error);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int k, len, vec_no, phase, size_now, pick, items_sent;
    logic [LLR_W-1:0] raw;
    bit steady;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_MODE;
    cfg_data  <= '0;
    directed_rows = '{
      '{ROW_LLR, 11'd0,       1'b1, 3'd0,          3'd0, 4'd0,  1'b1, '{6'd0, 1'b1, 1'b0}},
      '{ROW_LLR, 11'd1023,    1'b0, 3'd0,          3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_LLR, 11'h400,     1'b0, 3'd0,          3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_LLR, 11'd8,       1'b0, 3'd0,          3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_LLR, 11'd7,       1'b0, 3'd0,          3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_LLR, -11'sd24,    1'b0, 3'd0,          3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_LLR, 11'd496,     1'b1, 3'd0,          3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_CFG, 11'd0,       1'b0, MODE_MSB2,     3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_LLR, -11'sd200,   1'b0, 3'd0,          3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_LLR, 11'd100,     1'b1, 3'd0,          3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_CFG, 11'd0,       1'b0, MODE_MSB3,     3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_LLR, 11'd40,      1'b0, 3'd0,          3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_LLR, -11'sd40,    1'b1, 3'd0,          3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_CFG, 11'd0,       1'b0, MODE_MSB4,     3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_LLR, 11'd30,      1'b0, 3'd0,          3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_LLR, -11'sd47,    1'b1, 3'd0,          3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_CFG, 11'd0,       1'b0, MODE_MSB3_L1,  3'd3, 4'd1,  1'b0, NO_RESULT},
      '{ROW_LLR, 11'd64,      1'b0, 3'd0,          3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_LLR, 11'd80,      1'b0, 3'd0,          3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_LLR, -11'sd68,    1'b1, 3'd0,          3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_CFG, 11'd0,       1'b0, MODE_MSB3_L2,  3'd2, 4'd0,  1'b0, NO_RESULT},
      '{ROW_LLR, 11'd112,     1'b0, 3'd0,          3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_LLR, 11'd96,      1'b1, 3'd0,          3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_CFG, 11'd0,       1'b0, MODE_SPARE_LO, 3'd1, 4'd15, 1'b0, NO_RESULT},
      '{ROW_LLR, 11'd5,       1'b0, 3'd0,          3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_LLR, -11'sd5,     1'b0, 3'd0,          3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_LLR, 11'd300,     1'b1, 3'd0,          3'd0, 4'd0,  1'b1, '{6'd0, 1'b1, 1'b1}},
      '{ROW_CFG, 11'd0,       1'b0, MODE_SPARE_HI, 3'd7, 4'd2,  1'b0, NO_RESULT},
      '{ROW_LLR, -11'sd1,     1'b0, 3'd0,          3'd0, 4'd0,  1'b0, NO_RESULT},
      '{ROW_LLR, 11'd1,       1'b1, 3'd0,          3'd0, 4'd0,  1'b0, NO_RESULT}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG)
        set_config(directed_rows[r].mode, directed_rows[r].sort_log2, directed_rows[r].tie_log2);
      else
        send_llr(directed_rows[r].llr, directed_rows[r].last, directed_rows[r].typed,
                 directed_rows[r].want, 1'b0);
    end

    // The first random setting sorts by loaded count, so a full 64-entry vector and an
    // oversize load both come early.
    vec_no = 0;
    phase = 0;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      set_config(3'($urandom_range(0, 7)), (phase == 0) ? 3'd0 : 3'($urandom_range(0, 7)),
                 4'($urandom_range(0, $urandom_range(0, 1) ? 7 : 15)));
      size_now = (cur_sort == 0) ? 64 : (1 << ((cur_sort > 6) ? 6 : cur_sort));
      repeat ($urandom_range(3, 5)) begin
        pick = $urandom_range(0, 19);
        if (vec_no == 2 || pick == 0)
          len = MAX_LEN + $urandom_range(1, 3);
        else if (cur_sort != 0 && pick == 1)
          len = size_now + 1;
        else if (vec_no == 1 || pick == 2)
          len = (cur_sort == 0 && vec_no != 1) ? $urandom_range(33, 64) : size_now;
        else
          len = $urandom_range(1, (size_now < 12) ? size_now : 12);
        steady = ($urandom_range(0, 3) == 0);
        for (k = 0; k < len; k++) begin
          case ($urandom_range(0, 3))
            0:       raw = LLR_W'($urandom_range(0, 2047));
            1:       raw = LLR_W'($urandom_range(0, 40));
            2:       raw = LLR_W'($urandom_range(470, 520));
            default: raw = LLR_W'($urandom_range(0, 511));
          endcase
          if ($urandom_range(0, 1)) raw = -raw;
          send_llr(raw, k == len - 1, 1'b0, NO_RESULT, steady);
        end
        items_sent += len;
        vec_no++;
        if ($urandom_range(0, 4) == 0) begin
          s_tvalid <= 1'b0;
          wait_drained();
        end
      end
      phase++;
    end

    s_tvalid <= 1'b0;
    wait_drained();
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
